@@ rtl/pvd_pkg.sv @@
// Shared types, widths and a helper function for the prefix varint decoder.
// No dependencies; imported by every module of the block.
package pvd_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int LEN_W    = 4;
    localparam int LEFT_W   = 4;
    localparam int IDX_W    = 3;
    localparam int OUT_W    = 72;
    localparam int NLEAD_W  = 4;

    localparam logic [LEFT_W-1:0]  PAD_LEADS  = 4'd8;
    localparam logic [BYTE_W-1:0]  SHORT_LIM  = 8'h80;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] in_byte;
    } pvd_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] decoded_value;
        logic [LEN_W-1:0]   code_length;
    } pvd_result_t;

    function automatic logic [NLEAD_W-1:0] count_lead_ones(input logic [BYTE_W-1:0] b);
        logic [NLEAD_W-1:0] n;
        logic               stop;
        n    = '0;
        stop = 1'b0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (!stop && b[i]) begin
                n = n + 1'b1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/pvd_in_stage.sv @@
// Input register stage of the prefix varint decoder.
// Depends on pvd_pkg; feeds pvd_decode.
module pvd_in_stage
    import pvd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              take,
    output pvd_item_t         item
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign item.valid   = valid_reg;
    assign item.in_byte = byte_reg;

endmodule

@@ rtl/pvd_decode.sv @@
// Decode state, one-byte merge step and result register of the decoder.
// Depends on pvd_pkg; driven by pvd_in_stage.
module pvd_decode
    import pvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pvd_item_t   item,
    output logic        take,
    output logic        m_tvalid,
    input  logic        m_tready,
    output pvd_result_t result
);

    logic [LEFT_W-1:0]  bytes_left_reg,  bytes_left_next;
    logic [VALUE_W-1:0] acc_reg,         acc_next;
    logic [IDX_W-1:0]   idx_reg,         idx_next;
    logic               pad_reg,         pad_next;
    logic [LEN_W-1:0]   len_reg,         len_next;
    logic               m_valid_reg,     m_valid_next;
    pvd_result_t        res_reg,         res_next;

    logic               emit;
    logic [NLEAD_W-1:0] nlead;
    logic [BYTE_W-1:0]  lead_bits;
    logic [VALUE_W-1:0] merged;
    logic [LEFT_W-1:0]  left_dec;
    logic [LEN_W-1:0]   len_inc;
    logic [BYTE_W-1:0]  b;

    assign b         = item.in_byte;
    assign take      = item.valid && (!m_valid_reg || m_tready);
    assign nlead     = count_lead_ones(b);
    assign lead_bits = b & (8'hFF >> nlead);
    assign merged    = acc_reg | (VALUE_W'(b) << {idx_reg, 3'b000});
    assign left_dec  = bytes_left_reg - 1'b1;
    assign len_inc   = len_reg + 1'b1;

    always_comb begin
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        idx_next        = idx_reg;
        pad_next        = pad_reg;
        len_next        = len_reg;
        emit            = 1'b0;
        res_next        = res_reg;
        if (take) begin
            if (pad_reg) begin
                pad_next = 1'b0;
                len_next = len_inc;
            end else if (bytes_left_reg == '0) begin
                if (b < SHORT_LIM) begin
                    emit                   = 1'b1;
                    res_next.decoded_value = VALUE_W'(b);
                    res_next.code_length   = LEN_W'(1);
                end else begin
                    acc_next        = VALUE_W'(lead_bits) << {nlead, 3'b000};
                    bytes_left_next = LEFT_W'(nlead);
                    idx_next        = '0;
                    pad_next        = (LEFT_W'(nlead) == PAD_LEADS);
                    len_next        = LEN_W'(1);
                end
            end else begin
                acc_next        = merged;
                idx_next        = idx_reg + 1'b1;
                bytes_left_next = left_dec;
                len_next        = len_inc;
                if (left_dec == '0) begin
                    emit                   = 1'b1;
                    res_next.decoded_value = merged;
                    res_next.code_length   = len_inc;
                end
            end
        end
        m_valid_next = emit || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            idx_reg        <= '0;
            pad_reg        <= 1'b0;
            len_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            idx_reg        <= idx_next;
            pad_reg        <= pad_next;
            len_reg        <= len_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign result   = res_reg;

    a_pad_needs_eight: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_reg |-> bytes_left_reg == PAD_LEADS)
        else $error("pad pending without eight data bytes left");

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= PAD_LEADS)
        else $error("bytes left out of range");

    a_short_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.code_length == LEN_W'(1)) |->
            res_reg.decoded_value < VALUE_W'(SHORT_LIM))
        else $error("one-byte code with large value");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg)
        else $error("stalled result lost");

endmodule

@@ rtl/prefix_varint_decoder.sv @@
// Top level of the prefix varint decoder.
// Depends on pvd_pkg, pvd_in_stage and pvd_decode.
//
// Input channel s_*: one encoded byte per item, lead byte first.
// Result channel m_*: one item per completed code, holding the 64-bit
// value and the code length in bytes (1 to 10).
// Path: the final byte of a code passes through the input register,
// then the merge step into the result register.
// Throughput: one byte per cycle while no result waits on m_tready; the
// merge of a byte into the accumulator is a single shift and OR between
// the input register and the result register.
// Reset: aresetn low for one clock clears both valid flags and the
// decode state, so the next byte is taken as a lead byte.
// Stall: while m_tready is low a waiting result holds; the input
// register takes at most one more byte, then s_tready drops until the
// result is taken. No byte, not even one that produces no result,
// leaves the input register while the result waits.
module prefix_varint_decoder
    import pvd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [63:0] decoded_value, [67:64] code_length, rest 0
);

    pvd_item_t   item;
    pvd_result_t result;
    logic        take;

    pvd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    pvd_decode u_dec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = {{(OUT_W - VALUE_W - LEN_W){1'b0}}, result.code_length,
                      result.decoded_value};

endmodule

@@ tb/prefix_varint_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for prefix_varint_decoder: feeds prefix-coded bytes, predicts each
// decoded value and code length, and compares every result item. Depends on pvd_pkg and the RTL.
module prefix_varint_decoder_tb;
    import pvd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    pvd_result_t       expected_codes[$];
    int unsigned       err_count       = 0;
    int unsigned       bytes_sent      = 0;
    int unsigned       send_idle_pct   = 0;
    int unsigned       ready_stall_pct = 0;
    logic              m_hold          = 1'b0;

    logic [LEFT_W-1:0]  dec_left = '0;
    logic [VALUE_W-1:0] dec_acc  = '0;
    logic [IDX_W-1:0]   dec_pos  = '0;
    logic               dec_pad  = 1'b0;
    logic [LEN_W-1:0]   dec_len  = '0;

    prefix_varint_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned ones_before_zero(input logic [BYTE_W-1:0] b);
        int unsigned n;
        n = 0;
        while (n < 8 && b[7 - n]) n++;
        return n;
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        int unsigned n;
        pvd_result_t r;
        if (dec_pad) begin
            dec_pad = 1'b0;
            dec_len = dec_len + 1'b1;
            return;
        end
        if (dec_left == 0) begin
            if (b < SHORT_LIM) begin
                r.decoded_value = VALUE_W'(b);
                r.code_length   = LEN_W'(1);
                expected_codes.push_back(r);
                return;
            end
            n = ones_before_zero(b);
            if (n < 8)
                dec_acc = VALUE_W'(b & (8'hFF >> n)) << (8 * n);
            else
                dec_acc = '0;
            dec_left = LEFT_W'(n);
            dec_pos  = '0;
            dec_pad  = (n == 8);
            dec_len  = LEN_W'(1);
            return;
        end
        dec_acc  = dec_acc | (VALUE_W'(b) << (8 * dec_pos));
        dec_pos  = dec_pos + 1'b1;
        dec_left = dec_left - 1'b1;
        dec_len  = dec_len + 1'b1;
        if (dec_left == 0) begin
            r.decoded_value = dec_acc;
            r.code_length   = dec_len;
            expected_codes.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        m_tready <= !m_hold && ($urandom_range(99) >= ready_stall_pct);
    end

    always @(posedge aclk) begin
        pvd_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("unexpected item", m_tdata[VALUE_W-1:0], '0);
            end else begin
                want = expected_codes.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.decoded_value)
                    report_mismatch("decoded_value", m_tdata[VALUE_W-1:0], want.decoded_value);
                if (m_tdata[VALUE_W+LEN_W-1:VALUE_W] !== want.code_length)
                    report_mismatch("code_length", VALUE_W'(m_tdata[VALUE_W+LEN_W-1:VALUE_W]),
                                    VALUE_W'(want.code_length));
                if (m_tdata[OUT_W-1:VALUE_W+LEN_W] !== '0)
                    report_mismatch("tdata padding", VALUE_W'(m_tdata[OUT_W-1:VALUE_W+LEN_W]),
                                    '0);
            end
        end
    end

    initial begin
        int unsigned n;
        n = 0;
        while (n < CYCLE_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_byte(b);
        bytes_sent++;
    endtask

    // n = 0 is the one-byte form; otherwise a lead byte and n data bytes, plus a pad byte when n is 8
    task automatic send_code(input int unsigned n, input logic [VALUE_W-1:0] payload);
        logic [BYTE_W-1:0] lead;
        if (n == 0) begin
            send_byte({1'b0, payload[6:0]});
        end else if (n == 8) begin
            send_byte(8'hFF);
            send_byte(8'($urandom));
            for (int i = 0; i < 8; i++) send_byte(payload[8*i +: 8]);
        end else begin
            lead = 8'(8'hFF << (8 - n)) | (payload[63:56] & (8'hFF >> (n + 1)));
            send_byte(lead);
            for (int i = 0; i < n; i++) send_byte(payload[8*i +: 8]);
        end
    endtask

    task automatic send_random_code();
        int unsigned n;
        logic [VALUE_W-1:0] payload;
        n = ($urandom_range(99) < 30) ? 0 : $urandom_range(8, 1);
        payload = {$urandom, $urandom};
        case ($urandom_range(7))
            0: payload = '0;
            1: payload = '1;
            default: ;
        endcase
        send_code(n, payload);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (expected_codes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        send_byte(8'h00);
        send_byte(8'h7F);
        send_code(1, '1);
        send_code(2, 64'h0000_0000_0000_0080);
        send_code(7, '1);
        send_code(8, '1);
        wait_drain();
    endtask

    task automatic test_random_stream(input int unsigned idle_pct, input int unsigned stall_pct,
                                      input int unsigned n_bytes);
        int unsigned start;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            if ($urandom_range(99) < 8)
                send_byte(8'($urandom));
            else
                send_random_code();
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        fork
            begin
                m_hold <= 1'b1;
                repeat (200) @(posedge aclk);
                m_hold <= 1'b0;
            end
            begin
                for (int i = 0; i < 40; i++) send_code(0, 64'($urandom));
                for (int i = 0; i < 4; i++) send_random_code();
            end
        join
        wait_drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_stream(0, 0, 440);
        test_random_stream(59, 0, 440);
        test_random_stream(0, 59, 440);
        test_random_stream(11, 11, 440);
        test_backpressure();

        wait_drain();
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pvd_pkg.sv
rtl/pvd_in_stage.sv
rtl/pvd_decode.sv
rtl/prefix_varint_decoder.sv
tb/prefix_varint_decoder_tb.sv
